[hdl/ted_pkg.sv]
// shared types, constants and codes for the touch event decoder
package ted_pkg;

  // coordinate saturation width and derived datapath widths
  localparam int COORD_BITS = 16;
  localparam int OUT_W      = 16;
  localparam int RAW_W      = 32;
  localparam int BOUND_W    = 16;
  localparam int SIZE_W     = 12;
  localparam int DEN_W      = BOUND_W;
  localparam int PROD_W     = RAW_W + SIZE_W;
  localparam int QUO_W      = COORD_BITS + 1;
  localparam int QCNT_W     = $clog2(QUO_W);
  localparam int DSH_W      = DEN_W + COORD_BITS;
  localparam int CMP_W      = (PROD_W > DSH_W) ? PROD_W : DSH_W;
  localparam int SAT_W      = (COORD_BITS > OUT_W) ? COORD_BITS : OUT_W;

  // stream field widths
  localparam int KIND_W  = 2;
  localparam int CODE_W  = 16;
  localparam int PHASE_W = 2;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 64;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_X_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_X_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_Y_MIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_Y_MAX     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_AXES     = 3'd6;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_SYNC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ABS  = 2'd1;

  // absolute axis codes
  localparam logic [CODE_W-1:0] CODE_POS_X     = 16'd0;
  localparam logic [CODE_W-1:0] CODE_POS_Y     = 16'd1;
  localparam logic [CODE_W-1:0] CODE_PRESSURE  = 16'd24;
  localparam logic [CODE_W-1:0] CODE_MT_POS_X  = 16'd53;
  localparam logic [CODE_W-1:0] CODE_MT_POS_Y  = 16'd54;
  localparam logic [CODE_W-1:0] CODE_TRACK_ID  = 16'd57;

  localparam logic [RAW_W-1:0] TRACK_RELEASE = '1;

  // report phases
  localparam logic [PHASE_W-1:0] PHASE_BEGIN  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_CHANGE = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_END    = 2'd2;

  // register reset values
  localparam logic [SIZE_W-1:0]  RST_SCREEN_WIDTH  = 12'd800;
  localparam logic [SIZE_W-1:0]  RST_SCREEN_HEIGHT = 12'd480;
  localparam logic [BOUND_W-1:0] RST_RAW_X_MAX     = 16'd800;
  localparam logic [BOUND_W-1:0] RST_RAW_Y_MAX     = 16'd480;

  typedef enum logic [0:0] {
    TOP_IDLE,
    TOP_SCALE
  } top_state_t;

  typedef enum logic [1:0] {
    SCL_IDLE,
    SCL_MUL,
    SCL_DIV,
    SCL_DONE
  } scl_state_t;

  typedef struct packed {
    logic                     start;
    logic signed [RAW_W-1:0]  raw;
    logic [BOUND_W-1:0]       lo;
    logic [BOUND_W-1:0]       hi;
    logic [SIZE_W-1:0]        size;
  } scale_req_t;

  typedef struct packed {
    logic             done;
    logic [OUT_W-1:0] coord;
  } scale_rsp_t;

endpackage

[hdl/touch_event_decoder_core.sv]
// top level of the touch event decoder: event decode, touch state and report output
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tuser: kind; tdata: event_code, event_value
//  m_axis    out        tvalid/tready          tuser: touch_phase; tdata: four coordinates
//  cfg       in         cfg_we (no wait)       cfg_index, cfg_data
//
// sync, pressure, tracking id and ignored events need no scaler pass
// coordinate events pass through the scaler: the accept cycle for operand setup, the
// 32x12 multiply, 17 compare/subtract steps in the shared divider, then saturate and
// store; no new event is taken before the store
// a coordinate event whose calibration span is zero skips to the store
// a sync event waits while an earlier report still sits in the output register;
// other events go ahead regardless of m_axis_tready
// rst is synchronous: touch flags and points clear, registers take their defaults
module touch_event_decoder_core (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [ted_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ted_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input events
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ted_pkg::S_DATA_W-1:0]      s_axis_tdata,  // event_code[15:0], event_value[47:16]
  input  logic [ted_pkg::KIND_W-1:0]        s_axis_tuser,  // kind[1:0]
  // touch reports
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ted_pkg::M_DATA_W-1:0]      m_axis_tdata,  // first_x, first_y, second_x, second_y
  output logic [ted_pkg::PHASE_W-1:0]       m_axis_tuser   // touch_phase[1:0]
);
  import ted_pkg::*;

  // configuration registers
  logic [SIZE_W-1:0]  screen_width;
  logic [SIZE_W-1:0]  screen_height;
  logic [BOUND_W-1:0] raw_x_min;
  logic [BOUND_W-1:0] raw_x_max;
  logic [BOUND_W-1:0] raw_y_min;
  logic [BOUND_W-1:0] raw_y_max;
  logic               swap_axes;

  // touch state
  logic               start_pending;
  logic               end_pending;
  logic               touch_active;
  logic [OUT_W-1:0]   point_one_x;
  logic [OUT_W-1:0]   point_one_y;
  logic [OUT_W-1:0]   point_two_x;
  logic [OUT_W-1:0]   point_two_y;

  // pending coordinate target
  logic               tgt_second;
  logic               tgt_y;

  // report register
  logic [PHASE_W-1:0] phase;

  top_state_t state, state_next;

  scale_req_t req;
  scale_rsp_t rsp;

  // input field split
  logic [KIND_W-1:0] s_kind;
  logic [CODE_W-1:0] s_code;
  logic [RAW_W-1:0]  s_value;

  assign s_kind  = s_axis_tuser;
  assign s_code  = s_axis_tdata[CODE_W-1:0];
  assign s_value = s_axis_tdata[CODE_W +: RAW_W];

  logic accept;
  logic is_abs;
  logic is_sync;
  logic is_coord;
  logic code_second;
  logic code_y;
  logic axis_y;
  logic is_pressure;
  logic is_track;
  logic release_val;
  logic coord_start;
  logic report_load;

  assign accept      = s_axis_tvalid & s_axis_tready;
  assign is_abs      = (s_kind == KIND_ABS);
  assign is_sync     = (s_kind == KIND_SYNC);
  assign code_second = (s_code == CODE_MT_POS_X) || (s_code == CODE_MT_POS_Y);
  assign code_y      = (s_code == CODE_POS_Y) || (s_code == CODE_MT_POS_Y);
  assign is_coord    = (s_code == CODE_POS_X) || (s_code == CODE_POS_Y) || code_second;
  assign axis_y      = code_y ^ swap_axes;
  assign is_pressure = (s_code == CODE_PRESSURE);
  assign is_track    = (s_code == CODE_TRACK_ID);
  // release: pressure drops to zero or the tracking id goes to -1
  assign release_val = is_pressure ? (s_value == '0) : (s_value == TRACK_RELEASE);
  assign coord_start = accept & is_abs & is_coord;
  // a sync that produces a report
  assign report_load = accept & is_sync & (start_pending | end_pending | touch_active);

  // scaler request picks the calibration of the target axis
  assign req.start = coord_start;
  assign req.raw   = $signed(s_value);
  assign req.lo    = axis_y ? raw_y_min : raw_x_min;
  assign req.hi    = axis_y ? raw_y_max : raw_x_max;
  assign req.size  = axis_y ? screen_height : screen_width;

  ted_scaler u_scaler (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TOP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ready only between events; a sync also needs a free report register
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    unique case (state)
      TOP_IDLE: begin
        s_axis_tready = ~m_axis_tvalid | ~is_sync;
        if (coord_start) begin
          state_next = TOP_SCALE;
        end
      end
      TOP_SCALE: begin
        if (rsp.done) begin
          state_next = TOP_IDLE;
        end
      end
      default: state_next = TOP_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RST_SCREEN_WIDTH;
      screen_height <= RST_SCREEN_HEIGHT;
      raw_x_min     <= '0;
      raw_x_max     <= RST_RAW_X_MAX;
      raw_y_min     <= '0;
      raw_y_max     <= RST_RAW_Y_MAX;
      swap_axes     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data[SIZE_W-1:0];
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data[SIZE_W-1:0];
        CFG_RAW_X_MIN:     raw_x_min     <= cfg_data[BOUND_W-1:0];
        CFG_RAW_X_MAX:     raw_x_max     <= cfg_data[BOUND_W-1:0];
        CFG_RAW_Y_MIN:     raw_y_min     <= cfg_data[BOUND_W-1:0];
        CFG_RAW_Y_MAX:     raw_y_max     <= cfg_data[BOUND_W-1:0];
        CFG_SWAP_AXES:     swap_axes     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // remember which point/axis the scaler result goes to
  always_ff @(posedge clk) begin
    if (coord_start) begin
      tgt_second <= code_second;
      tgt_y      <= axis_y;
    end
  end

  // touch state, stored points and report register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pending <= 1'b0;
      end_pending   <= 1'b0;
      touch_active  <= 1'b0;
      point_one_x   <= '0;
      point_one_y   <= '0;
      point_two_x   <= '0;
      point_two_y   <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      phase         <= PHASE_BEGIN;
    end else begin
      // scaled coordinate lands in its point
      if (state == TOP_SCALE && rsp.done) begin
        unique case ({tgt_second, tgt_y})
          2'b00: point_one_x <= rsp.coord;
          2'b01: point_one_y <= rsp.coord;
          2'b10: point_two_x <= rsp.coord;
          2'b11: point_two_y <= rsp.coord;
          default: begin
          end
        endcase
      end

      // pressure or tracking id arms a start or an end
      if (accept && is_abs && (is_pressure || is_track)) begin
        if (release_val) begin
          if (touch_active) begin
            end_pending <= 1'b1;
          end
        end else if (!touch_active) begin
          start_pending <= 1'b1;
        end
      end

      // sync turns pending state into a report
      if (accept && is_sync) begin
        priority if (start_pending) begin
          start_pending <= 1'b0;
          touch_active  <= 1'b1;
          phase         <= PHASE_BEGIN;
        end else if (end_pending) begin
          end_pending   <= 1'b0;
          touch_active  <= 1'b0;
          phase         <= PHASE_END;
        end else if (touch_active) begin
          phase         <= PHASE_CHANGE;
        end else begin
        end
      end

      // report holds its own copy of the points, later coordinate events
      // may overwrite the points while it waits
      if (report_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {point_two_y, point_two_x, point_one_y, point_one_x};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tuser = phase;

endmodule

[hdl/ted_scaler.sv]
// iterative axis scaler: (raw - lo) * size / (hi - lo), saturated
module ted_scaler (
  input  logic               clk,
  input  logic               rst,
  input  ted_pkg::scale_req_t req,
  output ted_pkg::scale_rsp_t rsp
);
  import ted_pkg::*;

  scl_state_t state, state_next;

  logic              neg;
  logic [RAW_W-1:0]  diff_mag;
  logic [DEN_W-1:0]  den_mag;
  logic [SIZE_W-1:0] size;
  logic [CMP_W-1:0]  rem;
  logic [CMP_W-1:0]  dsh;
  logic [QUO_W-1:0]  quo;
  logic [QCNT_W-1:0] cnt;

  // operand preparation
  logic signed [RAW_W:0]   diff;
  logic [DEN_W:0]          den;
  logic [RAW_W:0]          diff_abs;
  logic [DEN_W:0]          den_abs;
  logic [PROD_W-1:0]       prod;
  logic [CMP_W:0]          sub;
  logic                    ge;

  assign diff     = $signed({req.raw[RAW_W-1], req.raw}) - $signed({1'b0, RAW_W'(req.lo)});
  assign den      = {1'b0, req.hi} - {1'b0, req.lo};
  assign diff_abs = diff[RAW_W] ? (RAW_W+1)'(-diff) : diff;
  assign den_abs  = den[DEN_W] ? (DEN_W+1)'(-den) : den;
  assign prod     = PROD_W'(diff_mag) * PROD_W'(size);

  // the shared compare and subtract
  assign sub = {1'b0, rem} - {1'b0, dsh};
  assign ge  = ~sub[CMP_W];

  // saturation to the coordinate range
  localparam logic [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic                         pos_ovf;
  logic                         neg_ovf;
  logic [QUO_W-1:0]             quo_neg;
  logic [COORD_BITS-1:0]        sat;
  logic signed [SAT_W-1:0]      sat_ext;

  assign pos_ovf = quo[COORD_BITS] | quo[COORD_BITS-1];
  assign neg_ovf = quo[COORD_BITS] | (quo[COORD_BITS-1] & (|quo[COORD_BITS-2:0]));
  assign quo_neg = -quo;
  assign sat     = neg ? (neg_ovf ? C_MIN : quo_neg[COORD_BITS-1:0])
                       : (pos_ovf ? C_MAX : quo[COORD_BITS-1:0]);
  assign sat_ext = SAT_W'($signed(sat));

  assign rsp.done  = (state == SCL_DONE);
  assign rsp.coord = sat_ext[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SCL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SCL_IDLE: begin
        if (req.start) begin
          state_next = (den == '0) ? SCL_DONE : SCL_MUL;
        end
      end
      SCL_MUL: state_next = SCL_DIV;
      SCL_DIV: begin
        if (cnt == '0) begin
          state_next = SCL_DONE;
        end
      end
      SCL_DONE: state_next = SCL_IDLE;
      default:  state_next = SCL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      SCL_IDLE: begin
        if (req.start) begin
          diff_mag <= diff_abs[RAW_W-1:0];
          den_mag  <= den_abs[DEN_W-1:0];
          size     <= req.size;
          neg      <= diff[RAW_W] ^ den[DEN_W];
          quo      <= '0;
        end
      end
      SCL_MUL: begin
        rem <= CMP_W'(prod);
        dsh <= CMP_W'(den_mag) << COORD_BITS;
        cnt <= QCNT_W'(QUO_W - 1);
      end
      SCL_DIV: begin
        if (ge) begin
          rem <= sub[CMP_W-1:0];
        end
        quo <= {quo[QUO_W-2:0], ge};
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
      end
      SCL_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule
